// File: sv/yaz0_pkg.sv
`default_nettype none
package yaz0_pkg;

  localparam int unsigned BEAT_BYTES = 8;
  localparam int unsigned HIST_AW    = 12;
  localparam logic [7:0]  LONG_BIAS  = 8'h12;
  localparam logic [3:0]  SHORT_BIAS = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic read;
    logic write;
    logic flush;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic starts_copy;
    logic is_literal;
    logic run_end;
    logic fill_last;
    logic fill_zero;
    logic slot_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/yaz0_in_if.sv
`default_nettype none
interface yaz0_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: sv/yaz0_out_if.sv
`default_nettype none
interface yaz0_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last;
  logic        done_res;
  logic        ref_error;
  modport source (output valid, output out_bytes, output byte_count, output last,
                  output done_res, output ref_error, input ready);
  modport sink (input valid, input out_bytes, input byte_count, input last,
                input done_res, input ref_error, output ready);
endinterface
`default_nettype wire

// File: sv/yaz0_lz_decompressor_core.sv
// Yaz0 decompressor core.
// Software strips the 16-byte stream header and writes the decompressed size
// to the size register through out_size_we/out_size_wdata while the core is idle.
// Compressed payload bytes enter on in_ch, one per transfer. Decompressed data
// leaves on out_ch as beats of up to eight bytes, first byte in bits 7:0.
// A flag byte or a partial back-reference is absorbed with no beat.
// A literal is accepted, then its beat is placed.
// A back-reference of length L is accepted, then takes one registered read
// and one write of the 4096-byte history memory per copied byte, then a read
// slot that sees the run end, and then the slot that places the last beat.
// The last beat of each literal or copy carries last; the beat holding the final
// byte of the stream carries done_res, and later input is consumed and dropped.
// When the receiver stalls, one finished beat waits in the output register
// while the next is assembled; the copy then pauses until the beat is taken.
// Reset clears the parse state and byte count; the history is not cleared.
`default_nettype none
module yaz0_lz_decompressor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        out_size_we,
  input  wire logic [31:0] out_size_wdata,
  yaz0_in_if.sink          in_ch,
  yaz0_out_if.source       out_ch
);

  yaz0_pkg::cmd_t  cmd;
  yaz0_pkg::stat_t stat;

  yaz0_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  yaz0_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (out_size_we),
    .cfg_wdata  (out_size_wdata),
    .in_byte    (in_ch.in_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_bytes  (out_ch.out_bytes),
    .byte_count (out_ch.byte_count),
    .last       (out_ch.last),
    .done_res   (out_ch.done_res),
    .ref_error  (out_ch.ref_error)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.byte_count != 4'd0) && (out_ch.byte_count <= 4'd8))
    else $error("beat byte count out of range");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.done_res) |-> out_ch.last)
    else $error("done beat not marked last");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.read || cmd.write || cmd.flush) |-> !in_ch.ready)
    else $error("input offered while a run is in progress");

endmodule
`default_nettype wire

// File: sv/yaz0_ctrl.sv
`default_nettype none
module yaz0_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire yaz0_pkg::stat_t stat,
  output yaz0_pkg::cmd_t       cmd
);

  yaz0_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= yaz0_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      yaz0_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (stat.starts_copy) begin
            state_next = yaz0_pkg::ST_READ;
          end else if (stat.is_literal) begin
            state_next = yaz0_pkg::ST_FLUSH;
          end
        end
      end
      yaz0_pkg::ST_READ: begin
        state_next = stat.run_end ? yaz0_pkg::ST_FLUSH : yaz0_pkg::ST_WRITE;
      end
      yaz0_pkg::ST_WRITE: begin
        if (!stat.fill_last || stat.slot_free) begin
          state_next = yaz0_pkg::ST_READ;
        end
      end
      yaz0_pkg::ST_FLUSH: begin
        if (stat.fill_zero || stat.slot_free) begin
          state_next = yaz0_pkg::ST_IDLE;
        end
      end
      default: state_next = yaz0_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      yaz0_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      yaz0_pkg::ST_READ: begin
        cmd.read = !stat.run_end;
      end
      yaz0_pkg::ST_WRITE: begin
        cmd.write = !stat.fill_last || stat.slot_free;
      end
      yaz0_pkg::ST_FLUSH: begin
        cmd.flush  = !stat.fill_zero && stat.slot_free;
        cmd.finish = stat.fill_zero || stat.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/yaz0_dp.sv
`default_nettype none
module yaz0_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire logic [7:0]     in_byte,
  input  wire yaz0_pkg::cmd_t cmd,
  output yaz0_pkg::stat_t     stat,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         out_bytes,
  output logic [3:0]          byte_count,
  output logic                last,
  output logic                done_res,
  output logic                ref_error
);

  localparam int unsigned AW = yaz0_pkg::HIST_AW;

  logic [7:0]    hist [2**AW];
  logic [31:0]   out_size;
  logic [31:0]   produced;
  logic [7:0]    flag_bits;
  logic [3:0]    groups_left;
  logic [1:0]    phase;
  logic [7:0]    held_first;
  logic [7:0]    held_second;
  logic          finished;
  logic [8:0]    run_left;
  logic [12:0]   src_dist;
  logic          rd_bad;
  logic [7:0]    rdata;
  logic [63:0]   acc;
  logic [3:0]    fill;
  logic          acc_err;

  logic          active;
  logic          starts_copy;
  logic          is_literal;
  logic [8:0]    copy_len;
  logic [12:0]   copy_dist;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    push_val;
  logic [63:0]   acc_new;
  logic          run_end;
  logic          slot_free;
  logic          byte_end;
  logic [31:0]   produced_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size <= '0;
    end else if (cfg_we) begin
      out_size <= cfg_wdata;
    end
  end

  assign active       = !finished && (produced < out_size);
  assign produced_inc = produced + 32'd1;

  // Decode the byte offered on the input against the parse state.
  always_comb begin
    starts_copy = 1'b0;
    is_literal  = 1'b0;
    copy_len    = {5'd0, held_first[7:4]} + {5'd0, yaz0_pkg::SHORT_BIAS};
    copy_dist   = {1'b0, held_first[3:0], in_byte} + 13'd1;
    if (active) begin
      priority if (phase == 2'd1) begin
        starts_copy = held_first[7:4] != 4'd0;
      end else if (phase == 2'd2) begin
        starts_copy = 1'b1;
        copy_len    = {1'b0, in_byte} + {1'b0, yaz0_pkg::LONG_BIAS};
        copy_dist   = {1'b0, held_first[3:0], held_second} + 13'd1;
      end else if (groups_left != 4'd0) begin
        is_literal = flag_bits[7];
      end
    end
  end

  assign run_end   = (run_left == 9'd0) || (produced >= out_size);
  assign slot_free = !out_valid || out_ready;
  assign push_val  = rd_bad ? 8'd0 : rdata;
  assign byte_end  = (run_left == 9'd1) || (produced_inc >= out_size);

  always_comb begin
    acc_new = acc;
    acc_new[{fill[2:0], 3'b000} +: 8] = push_val;
  end

  assign stat.starts_copy = starts_copy;
  assign stat.is_literal  = is_literal;
  assign stat.run_end     = run_end;
  assign stat.fill_last   = fill == 4'(yaz0_pkg::BEAT_BYTES - 1);
  assign stat.fill_zero   = fill == 4'd0;
  assign stat.slot_free   = slot_free;

  assign mem_we    = (cmd.accept && is_literal) || cmd.write;
  assign mem_wdata = cmd.write ? push_val : in_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[produced[AW-1:0]] <= mem_wdata;
    end
    if (cmd.read) begin
      rdata <= hist[produced[AW-1:0] - src_dist[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_bad <= produced < {19'd0, src_dist};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      produced    <= '0;
      flag_bits   <= '0;
      groups_left <= '0;
      phase       <= '0;
      held_first  <= '0;
      held_second <= '0;
      finished    <= 1'b0;
      run_left    <= '0;
      src_dist    <= '0;
      acc         <= '0;
      fill        <= '0;
      acc_err     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept && !finished) begin
        if (!active) begin
          finished <= 1'b1;
        end else if (phase == 2'd1 && held_first[7:4] == 4'd0) begin
          held_second <= in_byte;
          phase       <= 2'd2;
        end else if (starts_copy || (phase == 2'd0 && groups_left != 4'd0 && flag_bits[7]))
        begin
          if (phase == 2'd1) begin
            held_second <= in_byte;
          end
          run_left  <= copy_len;
          src_dist  <= copy_dist;
          flag_bits <= {flag_bits[6:0], 1'b0};
          groups_left <= groups_left - 4'd1;
          phase     <= 2'd0;
          if (is_literal) begin
            acc      <= {56'd0, in_byte};
            fill     <= 4'd1;
            acc_err  <= 1'b0;
            produced <= produced_inc;
          end
        end else if (groups_left == 4'd0) begin
          flag_bits   <= in_byte;
          groups_left <= 4'd8;
          phase       <= 2'd0;
        end else begin
          held_first <= in_byte;
          phase      <= 2'd1;
        end
      end
      if (cmd.write) begin
        produced <= produced_inc;
        run_left <= run_left - 9'd1;
        if (fill == 4'(yaz0_pkg::BEAT_BYTES - 1)) begin
          // A full beat moves to the output register right away.
          out_valid  <= 1'b1;
          out_bytes  <= acc_new;
          byte_count <= 4'(yaz0_pkg::BEAT_BYTES);
          last       <= byte_end;
          done_res   <= byte_end && (produced_inc >= out_size);
          ref_error  <= acc_err || rd_bad;
          acc        <= '0;
          fill       <= 4'd0;
          acc_err    <= 1'b0;
        end else begin
          acc     <= acc_new;
          fill    <= fill + 4'd1;
          acc_err <= acc_err || rd_bad;
        end
      end
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        out_bytes  <= acc;
        byte_count <= fill;
        last       <= 1'b1;
        done_res   <= produced >= out_size;
        ref_error  <= acc_err;
        acc        <= '0;
        fill       <= 4'd0;
        acc_err    <= 1'b0;
      end
      if (cmd.finish && (produced >= out_size)) begin
        finished <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
